>>> rtl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants for the sync/length/CRC deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 7;              // holds 0..MAX_PAYLOAD
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int CRC_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd235;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd144;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [CRC_W-1:0] CRC_MSB  = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_ID    = 3'd2,
        PH_LEN   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRCH  = 3'd5,
        PH_CRCL  = 3'd6,
        PH_READ  = 3'd7
    } phase_t;

    // control word from the parser to the CRC unit
    typedef struct packed {
        logic              init;
        logic              update;
        logic [BYTE_W-1:0] data;
    } crc_ctrl_t;

endpackage

>>> rtl/sync_length_crc_deframer_core.sv
// ----------------------------------------------------------------------------
// sync_length_crc_deframer_core
// Byte-stream frame parser: sync pair, id, length, payload, CRC-16 check,
// then read-out of the buffered payload of each good frame.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+---------------------------------------
//  s_       | in  | s_valid / s_ready  | s_in_byte
//  m_       | out | m_valid / m_ready  | m_message_id, m_frame_length,
//           |     |                    | m_has_payload, m_byte_index,
//           |     |                    | m_payload_byte, m_last
//  cfg_     | in  | cfg_wr_en          | cfg_index, cfg_wr_data
//
//  Flow: one received word per clock while parsing. The payload of a good
//  frame is then read out of the payload RAM: each word passes the RAM read
//  register, then the output register, and no new read is issued while one
//  is in flight or the output register is full; s_ready is low for the
//  whole read-out. An empty good frame costs nothing extra.
//  The final CRC word waits only while the output register is still full.
//  Reset: synchronous, active low; the payload RAM is not cleared, as only
//  entries written by the current frame are ever read.
//  Stalls: m_ready low holds the output register and pauses read-out.
// ----------------------------------------------------------------------------
module sync_length_crc_deframer_core
    import slcd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wr_data,
    // received bytes
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_in_byte,
    // frame words
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_W-1:0]    m_message_id,
    output logic [LEN_W-1:0]     m_frame_length,
    output logic                 m_has_payload,
    output logic [IDX_W-1:0]     m_byte_index,
    output logic [BYTE_W-1:0]    m_payload_byte,
    output logic                 m_last
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_wr_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parser state and frame context
    // ------------------------------------------------------------------
    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] id_reg;        // message id of the current frame
    logic [LEN_W-1:0]  len_reg;       // payload length of the current frame
    logic [LEN_W-1:0]  fill_reg;      // next payload write slot
    logic [BYTE_W-1:0] crch_reg;      // received CRC high byte
    logic [LEN_W-1:0]  rd_idx_reg;    // next payload read slot
    logic              rd_pending_reg;// RAM read in flight
    logic [IDX_W-1:0]  rd_addr_q;     // slot of the word in flight
    logic              rd_last_q;     // word in flight closes the frame

    // output register
    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_id_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_has_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;

    logic              s_fire;
    logic              out_free;
    logic              len_ok;
    logic [LEN_W-1:0]  fill_inc;
    logic [LEN_W-1:0]  rd_inc;
    logic [CRC_W-1:0]  crc_value;
    logic              crc_match;
    logic              load_empty;
    logic              rd_issue;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rd_data;
    crc_ctrl_t         crc_ctrl;

    assign s_fire    = s_valid && s_ready;
    assign out_free  = !out_valid_reg || m_ready;
    assign len_ok    = (s_in_byte <= BYTE_W'(MAX_PAYLOAD));
    assign fill_inc  = fill_reg + LEN_W'(1);
    assign rd_inc    = rd_idx_reg + LEN_W'(1);
    assign crc_match = ({crch_reg, s_in_byte} == crc_value);

    // ------------------------------------------------------------------
    // Next phase
    // ------------------------------------------------------------------
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT1: begin
                if (s_fire && s_in_byte == sync_first_reg) begin
                    phase_next = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                // a mismatch is not retried as a first sync byte
                if (s_fire) begin
                    phase_next = (s_in_byte == sync_second_reg) ? PH_ID : PH_HUNT1;
                end
            end
            PH_ID: begin
                if (s_fire) begin
                    phase_next = PH_LEN;
                end
            end
            PH_LEN: begin
                if (s_fire) begin
                    if (!len_ok) begin
                        phase_next = PH_HUNT1;
                    end else if (s_in_byte == '0) begin
                        phase_next = PH_CRCH;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (s_fire && fill_inc >= len_reg) begin
                    phase_next = PH_CRCH;
                end
            end
            PH_CRCH: begin
                if (s_fire) begin
                    phase_next = PH_CRCL;
                end
            end
            PH_CRCL: begin
                if (s_fire) begin
                    phase_next = (crc_match && len_reg != '0) ? PH_READ : PH_HUNT1;
                end
            end
            PH_READ: begin
                if (rd_issue && rd_inc == len_reg) begin
                    phase_next = PH_HUNT1;
                end
            end
            default: phase_next = PH_HUNT1;
        endcase
    end

    // ------------------------------------------------------------------
    // Phase outputs: handshake, CRC control, RAM ports
    // ------------------------------------------------------------------
    always_comb begin
        s_ready         = 1'b1;
        rd_issue        = 1'b0;
        ram_we          = 1'b0;
        load_empty      = 1'b0;
        crc_ctrl.init   = 1'b0;
        crc_ctrl.update = 1'b0;
        crc_ctrl.data   = s_in_byte;
        case (phase_reg)
            PH_HUNT2: begin
                crc_ctrl.init = s_fire && (s_in_byte == sync_second_reg);
            end
            PH_ID: begin
                crc_ctrl.update = s_fire;
            end
            PH_LEN: begin
                crc_ctrl.update = s_fire && len_ok;
            end
            PH_DATA: begin
                crc_ctrl.update = s_fire;
                ram_we          = s_fire;
            end
            PH_CRCL: begin
                // the empty-frame word goes straight to the output register
                s_ready    = out_free;
                load_empty = s_fire && crc_match && (len_reg == '0);
            end
            PH_READ: begin
                s_ready  = 1'b0;
                rd_issue = !rd_pending_reg && out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT1;
            id_reg         <= '0;
            len_reg        <= '0;
            fill_reg       <= '0;
            crch_reg       <= '0;
            rd_idx_reg     <= '0;
            rd_pending_reg <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            rd_pending_reg <= rd_issue;
            if (s_fire) begin
                case (phase_reg)
                    PH_ID: id_reg <= s_in_byte;
                    PH_LEN: begin
                        fill_reg <= '0;
                        if (len_ok) begin
                            len_reg <= s_in_byte[LEN_W-1:0];
                        end
                    end
                    PH_DATA: fill_reg   <= fill_inc;
                    PH_CRCH: crch_reg   <= s_in_byte;
                    PH_CRCL: rd_idx_reg <= '0;
                    default: ;
                endcase
            end else if (rd_issue) begin
                rd_idx_reg <= rd_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            rd_addr_q <= rd_idx_reg[IDX_W-1:0];
            rd_last_q <= (rd_inc == len_reg);
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_empty || rd_pending_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_empty) begin
            out_id_reg   <= id_reg;
            out_len_reg  <= '0;
            out_has_reg  <= 1'b0;
            out_idx_reg  <= '0;
            out_byte_reg <= '0;
            out_last_reg <= 1'b1;
        end else if (rd_pending_reg) begin
            out_id_reg   <= id_reg;
            out_len_reg  <= len_reg;
            out_has_reg  <= 1'b1;
            out_idx_reg  <= rd_addr_q;
            out_byte_reg <= ram_rd_data;
            out_last_reg <= rd_last_q;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_message_id   = out_id_reg;
    assign m_frame_length = out_len_reg;
    assign m_has_payload  = out_has_reg;
    assign m_byte_index   = out_idx_reg;
    assign m_payload_byte = out_byte_reg;
    assign m_last         = out_last_reg;

    // ------------------------------------------------------------------
    // Payload store and CRC unit
    // ------------------------------------------------------------------
    slcd_ram #(
        .DEPTH (MAX_PAYLOAD),
        .WIDTH (BYTE_W)
    ) u_payload_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg[IDX_W-1:0]),
        .wr_data (s_in_byte),
        .rd_en   (rd_issue),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    slcd_crc u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .crc     (crc_value)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // a RAM word landing must never overwrite a word still held
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pending_reg |-> !out_valid_reg)
        else $error("read data lands on a full output register");

    // payload is never written while a frame is being read out
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_issue |-> !ram_we && !s_fire)
        else $error("payload write during read-out");

    // read-out only ever runs for a non-empty frame
    a_read_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_READ) |-> (len_reg != '0) && (rd_idx_reg < len_reg))
        else $error("read-out past frame length");
`endif

endmodule

>>> rtl/slcd_ram.sv
// ----------------------------------------------------------------------------
// slcd_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slcd_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/slcd_crc.sv
// ----------------------------------------------------------------------------
// slcd_crc
// Running CRC-16/CCITT-FALSE, updated one byte per word.
// ----------------------------------------------------------------------------
module slcd_crc
    import slcd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  crc_ctrl_t        ctrl,
    output logic [CRC_W-1:0] crc
);

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;

    // eight shift/xor steps, MSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < BYTE_W; k++) begin
            if ((r & CRC_MSB) != '0) begin
                r = {r[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[CRC_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    always_comb begin
        crc_next = crc_reg;
        if (ctrl.init) begin
            crc_next = CRC_INIT;
        end else if (ctrl.update) begin
            crc_next = crc_byte(crc_reg, ctrl.data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else begin
            crc_reg <= crc_next;
        end
    end

    assign crc = crc_reg;

endmodule

>>> verif/slcd_checker.sv
// ----------------------------------------------------------------------------
// slcd_checker
// Watches the byte and frame-word channels of the deframer. It keeps its own
// copy of the parser and the sync registers, works out the frame words that
// each received byte releases and compares them, in order, with what the
// block puts out.
// ----------------------------------------------------------------------------
package slcd_tb_pkg;

    import slcd_pkg::*;

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = ((c & CRC_MSB) != '0) ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

endpackage

module slcd_checker
    import slcd_pkg::*;
    import slcd_tb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [BYTE_W-1:0]    s_in_byte,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [BYTE_W-1:0]    m_message_id,
    input  logic [LEN_W-1:0]     m_frame_length,
    input  logic                 m_has_payload,
    input  logic [IDX_W-1:0]     m_byte_index,
    input  logic [BYTE_W-1:0]    m_payload_byte,
    input  logic                 m_last,
    output int                   pending_words,
    output int                   fail_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0] message_id;
        logic [LEN_W-1:0]  frame_length;
        logic              has_payload;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic              last;
    } frame_word_t;

    // parser copy
    logic [BYTE_W-1:0] sync_first_r  = SYNC_FIRST_RST;
    logic [BYTE_W-1:0] sync_second_r = SYNC_SECOND_RST;
    phase_t            rx_phase      = PH_HUNT1;
    logic [BYTE_W-1:0] frame_id      = '0;
    logic [LEN_W-1:0]  frame_len     = '0;
    logic [LEN_W-1:0]  fill_count    = '0;
    logic [BYTE_W-1:0] payload_buf [MAX_PAYLOAD];
    logic [CRC_W-1:0]  crc_acc       = CRC_INIT;
    logic [BYTE_W-1:0] crc_high      = '0;

    frame_word_t frame_words_due[$];
    int          mismatch_count = 0;

    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
        frame_word_t w;
        case (rx_phase)
            PH_HUNT1: begin
                if (b == sync_first_r)
                    rx_phase = PH_HUNT2;
            end
            PH_HUNT2: begin
                // a wrong second byte is not retried as a first one
                if (b == sync_second_r) begin
                    crc_acc  = CRC_INIT;
                    rx_phase = PH_ID;
                end else begin
                    rx_phase = PH_HUNT1;
                end
            end
            PH_ID: begin
                frame_id = b;
                crc_acc  = crc16_step(crc_acc, b);
                rx_phase = PH_LEN;
            end
            PH_LEN: begin
                fill_count = '0;
                if (b > MAX_PAYLOAD) begin
                    rx_phase = PH_HUNT1;
                end else begin
                    frame_len = b[LEN_W-1:0];
                    crc_acc   = crc16_step(crc_acc, b);
                    rx_phase  = (b == '0) ? PH_CRCH : PH_DATA;
                end
            end
            PH_DATA: begin
                payload_buf[fill_count[IDX_W-1:0]] = b;
                crc_acc    = crc16_step(crc_acc, b);
                fill_count = fill_count + 1'b1;
                if (fill_count >= frame_len)
                    rx_phase = PH_CRCH;
            end
            PH_CRCH: begin
                crc_high = b;
                rx_phase = PH_CRCL;
            end
            PH_CRCL: begin
                rx_phase = PH_HUNT1;
                if ({crc_high, b} == crc_acc) begin
                    if (frame_len == '0) begin
                        w            = '0;
                        w.message_id = frame_id;
                        w.last       = 1'b1;
                        frame_words_due.push_back(w);
                    end else begin
                        for (int i = 0; i < frame_len; i++) begin
                            w.message_id   = frame_id;
                            w.frame_length = frame_len;
                            w.has_payload  = 1'b1;
                            w.byte_index   = IDX_W'(i);
                            w.payload_byte = payload_buf[i];
                            w.last         = (i == frame_len - 1);
                            frame_words_due.push_back(w);
                        end
                    end
                end
            end
            default: rx_phase = PH_HUNT1;
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        frame_word_t want;
        if (!aresetn) begin
            sync_first_r  = SYNC_FIRST_RST;
            sync_second_r = SYNC_SECOND_RST;
            rx_phase      = PH_HUNT1;
            frame_id      = '0;
            frame_len     = '0;
            fill_count    = '0;
            crc_acc       = CRC_INIT;
            crc_high      = '0;
            frame_words_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (frame_words_due.size() == 0) begin
                    $error("unexpected frame word: id 0x%0h len %0d idx %0d byte 0x%0h",
                           m_message_id, m_frame_length, m_byte_index, m_payload_byte);
                    mismatch_count++;
                end else begin
                    want = frame_words_due.pop_front();
                    check_field("message_id",   want.message_id,   m_message_id);
                    check_field("frame_length", want.frame_length, m_frame_length);
                    check_field("has_payload",  want.has_payload,  m_has_payload);
                    check_field("byte_index",   want.byte_index,   m_byte_index);
                    check_field("payload_byte", want.payload_byte, m_payload_byte);
                    check_field("last",         want.last,         m_last);
                end
            end
            if (s_valid && s_ready)
                parse_rx_byte(s_in_byte);
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SYNC_FIRST:  sync_first_r  = cfg_wr_data;
                    CFG_SYNC_SECOND: sync_second_r = cfg_wr_data;
                    default: ;
                endcase
            end
        end
        pending_words <= frame_words_due.size();
        fail_count    <= mismatch_count;
    end

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top level for the sync/length/CRC deframer. Builds byte streams of good,
// corrupted, over-length and broken frames plus noise, under several sync
// settings and handshake idling patterns; the checker beside the block
// predicts and compares every frame word.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import slcd_pkg::*;
    import slcd_tb_pkg::*;

    localparam real CLK_PERIOD   = 10.0;
    localparam int  RESET_CYCLES = 9;
    // ample slack for the read-out to settle once nothing is due
    localparam int  DRAIN_CYCLES = 16;
    // worst case is far below this even with every frame at full length and
    // both sides idling hard
    localparam int  CYCLE_LIMIT  = 400_000;
    localparam int  PHASE_ITEMS  = 6;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = CFG_SYNC_FIRST;
    logic [BYTE_W-1:0]    cfg_wr_data    = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_in_byte      = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [BYTE_W-1:0]    m_message_id;
    logic [LEN_W-1:0]     m_frame_length;
    logic                 m_has_payload;
    logic [IDX_W-1:0]     m_byte_index;
    logic [BYTE_W-1:0]    m_payload_byte;
    logic                 m_last;

    int                   pending_words;
    int                   fail_count;

    // stimulus state
    logic [BYTE_W-1:0]    tx_bytes[$];
    logic [BYTE_W-1:0]    cur_first      = SYNC_FIRST_RST;
    logic [BYTE_W-1:0]    cur_second     = SYNC_SECOND_RST;
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;
    int unsigned          cycle_count    = 0;

    always #(CLK_PERIOD / 2.0) aclk = ~aclk;

    sync_length_crc_deframer_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_message_id   (m_message_id),
        .m_frame_length (m_frame_length),
        .m_has_payload  (m_has_payload),
        .m_byte_index   (m_byte_index),
        .m_payload_byte (m_payload_byte),
        .m_last         (m_last)
    );

    slcd_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_message_id   (m_message_id),
        .m_frame_length (m_frame_length),
        .m_has_payload  (m_has_payload),
        .m_byte_index   (m_byte_index),
        .m_payload_byte (m_payload_byte),
        .m_last         (m_last),
        .pending_words  (pending_words),
        .fail_count     (fail_count)
    );

    // Receiver: ready drops at random per cycle, so stalls land on any beat
    // of the read-out, including the cycle the final CRC word waits on.
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Watchdog: a hung handshake or a word that never arrives ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Payload length for a random frame: mostly short, a few near the top.
    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(8);
        else if (r < 95)
            return $urandom_range(24, 9);
        return $urandom_range(MAX_PAYLOAD, 25);
    endfunction

    // Appends one frame to the transmit queue using the current sync pair.
    // Over-length frames stop at the length word: the parser is back in the
    // hunt by then and anything further would just be noise.
    task automatic queue_frame(input logic [BYTE_W-1:0] id, input int len,
                               input bit rand_fill, input logic [BYTE_W-1:0] fill,
                               input bit crc_good);
        logic [CRC_W-1:0]  crc;
        logic [BYTE_W-1:0] b;
        crc = CRC_INIT;
        tx_bytes.push_back(cur_first);
        tx_bytes.push_back(cur_second);
        tx_bytes.push_back(id);
        crc = crc16_step(crc, id);
        tx_bytes.push_back(BYTE_W'(len));
        if (len > MAX_PAYLOAD)
            return;
        crc = crc16_step(crc, BYTE_W'(len));
        for (int i = 0; i < len; i++) begin
            b = rand_fill ? BYTE_W'($urandom) : fill;
            tx_bytes.push_back(b);
            crc = crc16_step(crc, b);
        end
        // a single flipped bit is enough to break the check
        if (!crc_good)
            crc = crc ^ (CRC_W'(1) << $urandom_range(CRC_W - 1));
        tx_bytes.push_back(crc[15:8]);
        tx_bytes.push_back(crc[7:0]);
    endtask

    // Offers one word. Valid is only dropped for a gap, and a new word
    // follows the accepted one in the same step without lowering valid.
    task automatic send_word(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_queued();
        while (tx_bytes.size() != 0)
            send_word(tx_bytes.pop_front());
    endtask

    // Lowers valid at the edge of the last acceptance, then lets every
    // predicted word drain and the read-out settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_words != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes both sync registers on consecutive edges; only while idle.
    task automatic program_syncs(input logic [BYTE_W-1:0] first,
                                 input logic [BYTE_W-1:0] second);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_SYNC_FIRST;
        cfg_wr_data <= first;
        @(posedge aclk);
        cfg_index   <= CFG_SYNC_SECOND;
        cfg_wr_data <= second;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_first   = first;
        cur_second  = second;
    endtask

    // Mostly well-formed frames with random content, so the parser gets deep
    // into payload and CRC handling; the rest are corrupted CRCs, lengths
    // past the maximum, broken sync pairs and loose noise.
    task automatic random_traffic(input int n_items);
        int                sent;
        int                pick;
        logic [BYTE_W-1:0] b;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 62) begin
                queue_frame(BYTE_W'($urandom), pick_length(), 1'b1, '0, 1'b1);
            end else if (pick < 74) begin
                queue_frame(BYTE_W'($urandom), pick_length(), 1'b1, '0, 1'b0);
            end else if (pick < 82) begin
                queue_frame(BYTE_W'($urandom), $urandom_range(255, MAX_PAYLOAD + 1),
                            1'b1, '0, 1'b1);
            end else if (pick < 90) begin
                b = BYTE_W'($urandom);
                if (b == cur_second)
                    b = b ^ 8'h01;
                tx_bytes.push_back(cur_first);
                tx_bytes.push_back(b);
            end else begin
                repeat ($urandom_range(4, 1))
                    tx_bytes.push_back(BYTE_W'($urandom));
            end
            sent += tx_bytes.size();
            send_queued();
        end
    endtask

    task automatic run_phase(input bit reprogram,
                             input logic [BYTE_W-1:0] first,
                             input logic [BYTE_W-1:0] second,
                             input int idle_pct, input int stall_pct,
                             input bit full_frame);
        wait_idle();
        if (reprogram)
            program_syncs(first, second);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (full_frame) begin
            queue_frame(BYTE_W'($urandom), MAX_PAYLOAD, 1'b1, '0, 1'b1);
            send_queued();
        end
        random_traffic(PHASE_ITEMS);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset sync values, no idling.
        // Empty frame with an all-zero id: CRC follows the length directly.
        queue_frame(8'h00, 0, 1'b0, 8'h00, 1'b1);
        // One all-ones payload word under an all-ones id.
        queue_frame(8'hFF, 1, 1'b0, 8'hFF, 1'b1);
        // Corrupted CRC: the frame must vanish.
        queue_frame(8'h5A, 1, 1'b0, 8'h00, 1'b0);
        // Length one past the maximum sends the parser back to the hunt.
        queue_frame(8'h3C, MAX_PAYLOAD + 1, 1'b0, 8'h00, 1'b1);
        // First sync twice: the repeat is a bad second and is not retried,
        // so the following good frame must still be found afresh.
        tx_bytes.push_back(cur_first);
        tx_bytes.push_back(cur_first);
        queue_frame(8'hA5, 0, 1'b0, 8'h00, 1'b1);
        send_queued();

        // Random phases across sync settings and idling patterns.
        run_phase(1'b0, SYNC_FIRST_RST, SYNC_SECOND_RST, 0, 0, 1'b0);
        run_phase(1'b1, 8'h00, 8'hFF, 62, 0, 1'b0);
        run_phase(1'b1, 8'hFF, 8'h00, 0, 62, 1'b1);
        run_phase(1'b1, BYTE_W'($urandom), BYTE_W'($urandom), 8, 8, 1'b0);
        // identical sync bytes
        run_phase(1'b1, 8'h5A, 8'h5A, 0, 0, 1'b0);

        wait_idle();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
